/* src/assert_macros.svh */
// assertion macros used by the sector buffer cache engine module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold on every clock edge outside reset
`define SBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define SBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* src/sbc_pkg.sv */
// shared types and constants of the sector buffer cache
`default_nettype none
package sbc_pkg;
  localparam int unsigned CacheSlots = 64;
  localparam int unsigned SlotW = 6;
  localparam int unsigned SectorW = 32;
  localparam int unsigned PinW = 16;
  localparam int unsigned AgeW = 32;

  typedef enum logic [2:0] {
    ACT_LOAD  = 3'd0,
    ACT_READ  = 3'd1,
    ACT_WRITE = 3'd2,
    ACT_FREE  = 3'd3,
    ACT_FLUSH = 3'd4,
    ACT_CLEAR = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WRITE,
    ST_OUT,
    ST_FL_SCAN,
    ST_FL_OUT,
    ST_FL_END
  } state_t;

  // one result item
  typedef struct packed {
    logic               last;
    logic [SectorW-1:0] writeback_sector;
    logic               writeback_valid;
    logic               fetch_needed;
    logic [SlotW-1:0]   slot;
    logic               hit;
    logic               status;
  } result_t;

  // per-slot metadata word held in the memory
  typedef struct packed {
    logic [SectorW-1:0] tag;
    logic               dirty;
    logic [PinW-1:0]    pins;
    logic [AgeW-1:0]    age;
  } meta_t;
endpackage
`default_nettype wire

/* src/sbc_meta_ram.sv */
// metadata memory of the cache slots, one write and one registered read port
`default_nettype none
module sbc_meta_ram #(
  parameter int unsigned SLOTS = sbc_pkg::CacheSlots,
  parameter int unsigned IDXW = $clog2(SLOTS)
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [IDXW-1:0]     waddr,
  input  wire sbc_pkg::meta_t      wdata,
  input  wire logic [IDXW-1:0]     raddr,
  output sbc_pkg::meta_t           rdata
);
  sbc_pkg::meta_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/sector_buffer_cache_fifo.sv */
// Sector buffer cache metadata engine. Each access, free or flush item scans
// every slot through the metadata memory, one slot a cycle while no flush
// write-back waits on the output, using the registered read port. A flush or
// flush-and-clear gives one result per dirty slot, the last marked final, or
// a bare final result when no slot is dirty; an output stall holds its scan.
// An unknown action skips the scan and answers with a bare final result. The
// next item is accepted only once the final result has been taken and the
// engine is back in idle. Valid bits sit in flip-flops cleared by reset, so no
// clearing pass is needed. One item is in work at a time; a finished result
// sits in an output register while the next item waits.
`default_nettype none
`include "assert_macros.svh"
module sector_buffer_cache_fifo #(
  parameter int unsigned CACHE_SLOTS = sbc_pkg::CacheSlots
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [2:0] action, [34:3] sector, [39:35] zero
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] status, [1] hit, [7:2] slot, [8] fetch_needed, [9] writeback_valid,
  // [41:10] writeback_sector, [47:42] zero
  output logic [47:0]      m_tdata,
  output logic             m_tlast
);
  localparam int unsigned IDXW = $clog2(CACHE_SLOTS);
  localparam int unsigned CNTW = $clog2(CACHE_SLOTS + 1);
  localparam int unsigned SW = sbc_pkg::SlotW;

  sbc_pkg::state_t state, state_next;
  logic [2:0]  act;
  logic [31:0] sec;
  logic [CACHE_SLOTS-1:0] valid;
  logic [CNTW-1:0] occupancy;
  logic [31:0] age_counter;
  logic [IDXW-1:0] raddr;     // slot read at this edge
  logic            rd_step;   // issue the read of the next slot
  logic            rd_pend;   // read data for slot rd_idx arrives this cycle
  logic [IDXW-1:0] rd_idx;
  logic            rd_valid;  // valid bit of slot rd_idx, read with the memory
  logic            found;
  logic [IDXW-1:0] hit_idx;
  logic            free_found;
  logic [IDXW-1:0] free_idx;
  logic            vic_found;
  logic [IDXW-1:0] vic_idx;
  logic [31:0]     vic_dist;
  logic [IDXW-1:0] alloc_idx;
  sbc_pkg::meta_t  hit_meta, vic_meta, rdata, wdata;
  logic            we;
  logic [IDXW-1:0] waddr;
  logic            any_wb;
  logic            fl_emit;
  sbc_pkg::result_t res, held, wb_res, end_res;
  logic            out_valid;
  logic            last_slot;

  sbc_meta_ram #(.SLOTS(CACHE_SLOTS), .IDXW(IDXW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign s_tready = (state == sbc_pkg::ST_IDLE) && !out_valid;
  assign m_tvalid = out_valid;
  assign m_tdata = {6'd0, res.writeback_sector, res.writeback_valid, res.fetch_needed,
                    res.slot, res.hit, res.status};
  assign m_tlast = res.last;
  assign last_slot = (rd_idx == IDXW'(CACHE_SLOTS - 1));
  assign raddr = (state == sbc_pkg::ST_IDLE) ? '0 : rd_idx + IDXW'(1);
  // a write-back goes out only once a later dirty slot shows it is not the final one
  assign fl_emit = rd_pend && rd_valid && rdata.dirty && any_wb;

  always_comb begin
    wb_res = '0;
    wb_res.slot = SW'(rd_idx);
    wb_res.writeback_valid = 1'b1;
    wb_res.writeback_sector = rdata.tag;
    end_res = any_wb ? held : '0;
    end_res.last = 1'b1;
  end

  always_comb begin
    rd_step = 1'b0;
    case (state)
      sbc_pkg::ST_IDLE: rd_step = s_tvalid && s_tready && (s_tdata[2:0] <= sbc_pkg::ACT_CLEAR);
      sbc_pkg::ST_SCAN: rd_step = rd_pend && !last_slot;
      sbc_pkg::ST_FL_SCAN: rd_step = rd_pend && !fl_emit && !last_slot;
      sbc_pkg::ST_FL_OUT: rd_step = !out_valid && !last_slot;
      default: rd_step = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      sbc_pkg::ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          if (s_tdata[2:0] == sbc_pkg::ACT_FLUSH || s_tdata[2:0] == sbc_pkg::ACT_CLEAR) begin
            state_next = sbc_pkg::ST_FL_SCAN;
          end else if (s_tdata[2:0] <= sbc_pkg::ACT_FREE) begin
            state_next = sbc_pkg::ST_SCAN;
          end else begin
            // unknown action: bare final marker
            state_next = sbc_pkg::ST_FL_END;
          end
        end
      end
      sbc_pkg::ST_SCAN: if (rd_pend && last_slot) state_next = sbc_pkg::ST_DECIDE;
      sbc_pkg::ST_DECIDE: state_next = sbc_pkg::ST_WRITE;
      sbc_pkg::ST_WRITE: state_next = sbc_pkg::ST_OUT;
      sbc_pkg::ST_OUT: if (!out_valid) state_next = sbc_pkg::ST_IDLE;
      sbc_pkg::ST_FL_SCAN: begin
        if (fl_emit) state_next = sbc_pkg::ST_FL_OUT;
        else if (rd_pend && last_slot) state_next = sbc_pkg::ST_FL_END;
      end
      sbc_pkg::ST_FL_OUT: begin
        if (!out_valid) begin
          state_next = last_slot ? sbc_pkg::ST_FL_END : sbc_pkg::ST_FL_SCAN;
        end
      end
      sbc_pkg::ST_FL_END: if (!out_valid) state_next = sbc_pkg::ST_OUT;
      default: state_next = sbc_pkg::ST_IDLE;
    endcase
  end

  // memory write port: decided access, or dirty clear during flush
  always_comb begin
    we = 1'b0;
    waddr = hit_idx;
    wdata = hit_meta;
    case (state)
      sbc_pkg::ST_WRITE: begin
        if (act != sbc_pkg::ACT_FREE && res.status == 1'b0) begin
          we = 1'b1;
          if (found) begin
            waddr = hit_idx;
            wdata = hit_meta;
            if (act == sbc_pkg::ACT_LOAD && hit_meta.pins != '1) begin
              wdata.pins = hit_meta.pins + sbc_pkg::PinW'(1);
            end
            if (act == sbc_pkg::ACT_WRITE) wdata.dirty = 1'b1;
          end else begin
            waddr = alloc_idx;
            wdata.tag = sec;
            wdata.dirty = (act == sbc_pkg::ACT_WRITE);
            wdata.pins = (act == sbc_pkg::ACT_LOAD) ? sbc_pkg::PinW'(1) : '0;
            wdata.age = age_counter;
          end
        end
      end
      sbc_pkg::ST_FL_SCAN: begin
        if (rd_pend && rd_valid && rdata.dirty) begin
          we = 1'b1;
          waddr = rd_idx;
          wdata = rdata;
          wdata.dirty = 1'b0;
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbc_pkg::ST_IDLE;
      valid <= '0;
      occupancy <= '0;
      age_counter <= '0;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && m_tready) out_valid <= 1'b0;
      rd_pend <= rd_step;
      if (rd_step) rd_idx <= (state == sbc_pkg::ST_IDLE) ? '0 : rd_idx + IDXW'(1);
      rd_valid <= valid[raddr];
      case (state)
        sbc_pkg::ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            act <= s_tdata[2:0];
            sec <= s_tdata[34:3];
            found <= 1'b0;
            free_found <= 1'b0;
            vic_found <= 1'b0;
            any_wb <= 1'b0;
            res <= '0;
          end
        end
        sbc_pkg::ST_SCAN: begin
          if (rd_pend) begin
            if (rd_valid) begin
              if (!found && rdata.tag == sec) begin
                found <= 1'b1;
                hit_idx <= rd_idx;
                hit_meta <= rdata;
              end
              if (rdata.pins == '0 && (!vic_found
                  || (age_counter - rdata.age) > vic_dist)) begin
                vic_found <= 1'b1;
                vic_idx <= rd_idx;
                vic_meta <= rdata;
                vic_dist <= age_counter - rdata.age;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx <= rd_idx;
            end
          end
        end
        sbc_pkg::ST_DECIDE: begin
          res.last <= 1'b1;
          if (found) begin
            res.hit <= 1'b1;
            res.slot <= SW'(hit_idx);
          end else if (act == sbc_pkg::ACT_FREE) begin
            res.slot <= '0;
          end else if (occupancy >= CNTW'(CACHE_SLOTS)) begin
            if (!vic_found) begin
              res.status <= 1'b1;
            end else begin
              alloc_idx <= vic_idx;
              res.slot <= SW'(vic_idx);
              res.fetch_needed <= 1'b1;
              res.writeback_valid <= vic_meta.dirty;
              res.writeback_sector <= vic_meta.dirty ? vic_meta.tag : '0;
            end
          end else if (free_found) begin
            alloc_idx <= free_idx;
            res.slot <= SW'(free_idx);
            res.fetch_needed <= 1'b1;
          end else begin
            res.status <= 1'b1;
          end
        end
        sbc_pkg::ST_WRITE: begin
          out_valid <= 1'b1;
          if (act == sbc_pkg::ACT_FREE) begin
            if (found) begin
              valid[hit_idx] <= 1'b0;
              if (occupancy != '0) occupancy <= occupancy - CNTW'(1);
            end
          end else if (!found && res.status == 1'b0) begin
            valid[alloc_idx] <= 1'b1;
            age_counter <= age_counter + 32'd1;
            if (occupancy < CNTW'(CACHE_SLOTS)) occupancy <= occupancy + CNTW'(1);
          end
        end
        sbc_pkg::ST_FL_SCAN: begin
          if (rd_pend) begin
            if (rd_valid && rdata.dirty) begin
              held <= wb_res;
              any_wb <= 1'b1;
              if (any_wb) begin
                res <= held;
                out_valid <= 1'b1;
              end
            end
            if (act == sbc_pkg::ACT_CLEAR) valid[rd_idx] <= 1'b0;
          end
        end
        sbc_pkg::ST_FL_END: begin
          // final result carries the last held write-back, or stands alone
          if (!out_valid) begin
            res <= end_res;
            out_valid <= 1'b1;
            if (act == sbc_pkg::ACT_CLEAR) occupancy <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `SBC_ASSERT(a_occ_range, occupancy <= CNTW'(CACHE_SLOTS), "occupancy above slot count")
  `SBC_ASSERT(a_ready_idle, !s_tready || (state == sbc_pkg::ST_IDLE), "ready outside idle")
  `SBC_ASSERT_NEXT(a_age_step, state == sbc_pkg::ST_SCAN && state_next == sbc_pkg::ST_DECIDE,
    $stable(age_counter), "age moved during decide")
endmodule
`default_nettype wire

/* test/sector_buffer_cache_fifo_tb.sv */
// testbench of the sector buffer cache metadata engine: table, fill phases and random traffic
`default_nettype none
module sector_buffer_cache_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;
  localparam logic [15:0] PinMax = 16'hFFFF;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned LongHold = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;

  sector_buffer_cache_fifo u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // predicted cache metadata
  logic                        c_valid [sbc_pkg::CacheSlots];
  logic [sbc_pkg::SectorW-1:0] c_tag   [sbc_pkg::CacheSlots];
  logic                        c_dirty [sbc_pkg::CacheSlots];
  logic [sbc_pkg::PinW-1:0]    c_pins  [sbc_pkg::CacheSlots];
  logic [sbc_pkg::AgeW-1:0]    c_age   [sbc_pkg::CacheSlots];
  logic [sbc_pkg::AgeW-1:0]    c_clock;
  int unsigned                 c_count;

  sbc_pkg::result_t pending_results[$];
  int      errors = 0;
  bit      stall_now = 0;

  function automatic sbc_pkg::result_t mk(logic st, logic h, logic [5:0] sl, logic f,
                                          logic wv, logic [31:0] ws, logic l);
    sbc_pkg::result_t r;
    r.status = st; r.hit = h; r.slot = sl; r.fetch_needed = f;
    r.writeback_valid = wv; r.writeback_sector = ws; r.last = l;
    return r;
  endfunction

  function automatic int find_sector(logic [31:0] sec);
    for (int i = 0; i < sbc_pkg::CacheSlots; i++)
      if (c_valid[i] && c_tag[i] == sec) return i;
    return -1;
  endfunction

  function automatic void access_cache(logic [31:0] sec, bit pin_up, bit make_dirty);
    int s;
    logic wv;
    logic [31:0] ws;
    logic [31:0] best, a;
    s = find_sector(sec);
    wv = 1'b0;
    ws = '0;
    best = '0;
    if (s >= 0) begin
      if (pin_up && c_pins[s] < PinMax) c_pins[s]++;
      if (make_dirty) c_dirty[s] = 1'b1;
      pending_results.push_back(mk(1'b0, 1'b1, s[5:0], 1'b0, 1'b0, 32'd0, 1'b1));
      return;
    end
    if (c_count >= sbc_pkg::CacheSlots) begin
      for (int i = 0; i < sbc_pkg::CacheSlots; i++) begin
        if (c_valid[i] && c_pins[i] == '0) begin
          a = c_clock - c_age[i];
          if (s < 0 || a > best) begin
            s = i;
            best = a;
          end
        end
      end
      if (s < 0) begin
        pending_results.push_back(mk(1'b1, 1'b0, 6'd0, 1'b0, 1'b0, 32'd0, 1'b1));
        return;
      end
      if (c_dirty[s]) begin
        wv = 1'b1;
        ws = c_tag[s];
      end
      c_valid[s] = 1'b0;
      c_count--;
    end else begin
      for (int i = 0; i < sbc_pkg::CacheSlots; i++)
        if (!c_valid[i]) begin
          s = i;
          break;
        end
      if (s < 0) begin
        pending_results.push_back(mk(1'b1, 1'b0, 6'd0, 1'b0, 1'b0, 32'd0, 1'b1));
        return;
      end
    end
    c_valid[s] = 1'b1;
    c_tag[s] = sec;
    c_dirty[s] = make_dirty;
    c_pins[s] = pin_up ? 16'd1 : 16'd0;
    c_age[s] = c_clock;
    c_clock++;
    c_count++;
    pending_results.push_back(mk(1'b0, 1'b0, s[5:0], 1'b1, wv, ws, 1'b1));
  endfunction

  function automatic void flush_cache(bit clear);
    int n;
    n = 0;
    for (int i = 0; i < sbc_pkg::CacheSlots; i++) begin
      if (c_valid[i] && c_dirty[i]) begin
        pending_results.push_back(mk(1'b0, 1'b0, i[5:0], 1'b0, 1'b1, c_tag[i], 1'b0));
        c_dirty[i] = 1'b0;
        n++;
      end
      if (clear) c_valid[i] = 1'b0;
    end
    if (clear) c_count = 0;
    if (n == 0) pending_results.push_back(mk(1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 32'd0, 1'b1));
    else pending_results[$].last = 1'b1;
  endfunction

  function automatic void predict_cache(logic [2:0] act, logic [31:0] sec);
    int s;
    case (act)
      sbc_pkg::ACT_LOAD:  access_cache(sec, 1'b1, 1'b0);
      sbc_pkg::ACT_READ:  access_cache(sec, 1'b0, 1'b0);
      sbc_pkg::ACT_WRITE: access_cache(sec, 1'b0, 1'b1);
      sbc_pkg::ACT_FREE: begin
        s = find_sector(sec);
        if (s >= 0) begin
          c_valid[s] = 1'b0;
          if (c_count > 0) c_count--;
          pending_results.push_back(mk(1'b0, 1'b1, s[5:0], 1'b0, 1'b0, 32'd0, 1'b1));
        end else begin
          pending_results.push_back(mk(1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 32'd0, 1'b1));
        end
      end
      sbc_pkg::ACT_FLUSH: flush_cache(1'b0);
      sbc_pkg::ACT_CLEAR: flush_cache(1'b1);
      default: pending_results.push_back(mk(1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 32'd0, 1'b1));
    endcase
  endfunction

  // offer one request after a random idle gap; valid stays high across back-to-back transfers when the gap is zero
  task automatic send_request(logic [2:0] act, logic [31:0] sec, bit typed,
                              sbc_pkg::result_t typed_res);
    int gap;
    int n;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, sec, act};
    do @(posedge clk); while (!s_tready);
    if (typed) begin
      n = pending_results.size();
      predict_cache(act, sec);
      while (pending_results.size() > n) void'(pending_results.pop_back());
      pending_results.push_back(typed_res);
    end else begin
      predict_cache(act, sec);
    end
  endtask

  task automatic check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    sbc_pkg::result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", m_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, m_tdata[0]);
        check_field("hit", e.hit, m_tdata[1]);
        check_field("slot", e.slot, m_tdata[7:2]);
        check_field("fetch_needed", e.fetch_needed, m_tdata[8]);
        check_field("writeback_valid", e.writeback_valid, m_tdata[9]);
        check_field("writeback_sector", e.writeback_sector, m_tdata[41:10]);
        check_field("last", e.last, m_tlast);
      end
    end
  end

  // receiver with random back-pressure and one long hold
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (stall_now) begin
        stall_now = 0;
        gap = LongHold;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  typedef struct {
    logic [2:0]       act;
    logic [31:0]      sec;
    bit               typed;
    sbc_pkg::result_t res;
  } stim_row_t;

  stim_row_t rows[16];
  logic [31:0] sector_pool[80];

  initial begin
    logic [2:0] act;
    logic [31:0] sec;
    int pick;
    for (int i = 0; i < sbc_pkg::CacheSlots; i++) begin
      c_valid[i] = 1'b0; c_tag[i] = '0; c_dirty[i] = 1'b0; c_pins[i] = '0; c_age[i] = '0;
    end
    c_clock = '0;
    c_count = 0;

    rows[0]  = '{sbc_pkg::ACT_READ,  32'h0, 1'b1,
                 mk(1'b0, 1'b0, 6'd0, 1'b1, 1'b0, 32'd0, 1'b1)};
    rows[1]  = '{sbc_pkg::ACT_FLUSH, 32'h0, 1'b1,
                 mk(1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 32'd0, 1'b1)};
    rows[2]  = '{sbc_pkg::ACT_FREE,  32'h5, 1'b1,
                 mk(1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 32'd0, 1'b1)};
    rows[3]  = '{ACT_RSVD6, 32'hFFFFFFFF, 1'b1,
                 mk(1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 32'd0, 1'b1)};
    rows[4]  = '{ACT_RSVD7, 32'h0, 1'b1,
                 mk(1'b0, 1'b0, 6'd0, 1'b0, 1'b0, 32'd0, 1'b1)};
    rows[5]  = '{sbc_pkg::ACT_LOAD,  32'hFFFFFFFF, 1'b1,
                 mk(1'b0, 1'b0, 6'd1, 1'b1, 1'b0, 32'd0, 1'b1)};
    rows[6]  = '{sbc_pkg::ACT_LOAD,  32'hFFFFFFFF, 1'b1,
                 mk(1'b0, 1'b1, 6'd1, 1'b0, 1'b0, 32'd0, 1'b1)};
    rows[7]  = '{sbc_pkg::ACT_WRITE, 32'h0, 1'b1,
                 mk(1'b0, 1'b1, 6'd0, 1'b0, 1'b0, 32'd0, 1'b1)};
    rows[8]  = '{sbc_pkg::ACT_WRITE, 32'h12345678, 1'b0, '0};
    rows[9]  = '{sbc_pkg::ACT_READ,  32'hFFFFFFFF, 1'b0, '0};
    rows[10] = '{sbc_pkg::ACT_FLUSH, 32'h0, 1'b0, '0};
    rows[11] = '{sbc_pkg::ACT_FLUSH, 32'h0, 1'b0, '0};
    rows[12] = '{sbc_pkg::ACT_WRITE, 32'hAAAAAAAA, 1'b0, '0};
    rows[13] = '{sbc_pkg::ACT_FREE,  32'hFFFFFFFF, 1'b0, '0};
    rows[14] = '{sbc_pkg::ACT_CLEAR, 32'h0, 1'b0, '0};
    rows[15] = '{sbc_pkg::ACT_READ,  32'h55555555, 1'b0, '0};
    for (int i = 0; i < 80; i++) sector_pool[i] = $urandom();
    sector_pool[0] = 32'h0;
    sector_pool[1] = 32'hFFFFFFFF;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_request(rows[i].act, rows[i].sec, rows[i].typed, rows[i].res);

    // empty the cache and wait until everything has drained
    send_request(sbc_pkg::ACT_CLEAR, 32'h0, 1'b0, '0);
    s_tvalid <= 1'b0;
    wait (pending_results.size() == 0);

    // pin every slot while the receiver holds off; the next miss finds no victim
    stall_now = 1;
    for (int i = 0; i < sbc_pkg::CacheSlots; i++) begin
      send_request(sbc_pkg::ACT_LOAD, 32'h8000_0000 + 32'(i), 1'b0, '0);
    end
    send_request(sbc_pkg::ACT_READ, 32'h7, 1'b0, '0);
    // two unpinned dirty slots, then a miss evicts the older one with write-back
    send_request(sbc_pkg::ACT_FREE, 32'h8000_0003, 1'b0, '0);
    send_request(sbc_pkg::ACT_FREE, 32'h8000_0005, 1'b0, '0);
    send_request(sbc_pkg::ACT_WRITE, 32'h7, 1'b0, '0);
    send_request(sbc_pkg::ACT_WRITE, 32'h9, 1'b0, '0);
    send_request(sbc_pkg::ACT_READ, 32'hB, 1'b0, '0);
    send_request(sbc_pkg::ACT_CLEAR, 32'h0, 1'b0, '0);

    for (int n = 0; n < 32; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) act = sbc_pkg::ACT_LOAD;
      else if (pick < 50) act = sbc_pkg::ACT_READ;
      else if (pick < 70) act = sbc_pkg::ACT_WRITE;
      else if (pick < 82) act = sbc_pkg::ACT_FREE;
      else if (pick < 90) act = sbc_pkg::ACT_FLUSH;
      else if (pick < 94) act = sbc_pkg::ACT_CLEAR;
      else act = ($urandom_range(0, 1) != 0) ? ACT_RSVD6 : ACT_RSVD7;
      sec = ($urandom_range(0, 4) == 0) ? $urandom() : sector_pool[$urandom_range(0, 79)];
      send_request(act, sec, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
